// File: hdl/efc_pkg.sv
package efc_pkg;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned STATUS_W  = 3;
  localparam int unsigned PLEN_W    = 16;
  localparam int unsigned POS_W     = 17;

  localparam logic [DATA_W-1:0] START_WORD  = 32'h7fff0008;
  localparam logic [DATA_W-1:0] MARKER_WORD = 32'hfffffafa;
  localparam logic [DATA_W-1:0] FOOTER_WORD = 32'hfffff5f5;
  localparam logic [DATA_W-1:0] END_WORD    = 32'h7fff0009;

  localparam logic [DATA_W-1:0] LEN_OFFSET   = 32'd7;
  localparam logic [DATA_W-1:0] HEADER_WORDS = 32'd13;
  localparam logic [DATA_W-1:0] PAYLOAD_LIMIT = 32'd65536;

  localparam logic [POS_W-1:0] POS_START  = 17'd0;
  localparam logic [POS_W-1:0] POS_MARKER = 17'd7;
  localparam logic [POS_W-1:0] POS_LENGTH = 17'd8;
  localparam logic [POS_W-1:0] POS_SUM_LO = 17'd9;
  localparam logic [POS_W-1:0] POS_SUM_HI = 17'd11;
  localparam logic [POS_W-1:0] POS_SIZE   = 17'd12;
  localparam logic [POS_W-1:0] POS_MAX    = 17'h1ffff;

  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_START    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_MARKER   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_MISMATCH = 3'd3;
  localparam logic [STATUS_W-1:0] ST_RANGE    = 3'd4;
  localparam logic [STATUS_W-1:0] ST_FOOTER   = 3'd5;
  localparam logic [STATUS_W-1:0] ST_END      = 3'd6;
  localparam logic [STATUS_W-1:0] ST_LENGTH   = 3'd7;

  typedef struct packed {
    logic [DATA_W-1:0] data_word;
    logic              last_word;
  } word_t;

endpackage

// File: hdl/efc_ifs.sv
interface efc_in_if import efc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] data_word;
  logic              last_word;

  modport source (output valid, data_word, last_word, input ready);
  modport sink   (input valid, data_word, last_word, output ready);
endinterface

interface efc_out_if import efc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [PLEN_W-1:0]   payload_words;

  modport source (output valid, status, payload_words, input ready);
  modport sink   (input valid, status, payload_words, output ready);
endinterface

// File: hdl/efc_in_stage.sv
module efc_in_stage import efc_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  up_valid,
  output logic  up_ready,
  input  word_t up_word,
  output logic  dn_valid,
  input  logic  dn_ready,
  output word_t dn_word
);

  logic  valid_r;
  logic  valid_nxt;
  word_t word_r;

  assign up_ready  = !valid_r || dn_ready;
  assign valid_nxt = up_valid || (valid_r && !dn_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= valid_nxt;
    end
  end

  // hold the word while the core stalls
  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      word_r <= up_word;
    end
  end

  assign dn_valid = valid_r;
  assign dn_word  = word_r;

endmodule

// File: hdl/efc_core.sv
module efc_core import efc_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                up_valid,
  output logic                up_ready,
  input  word_t               up_word,
  output logic                res_valid,
  input  logic                res_ready,
  output logic [STATUS_W-1:0] res_status,
  output logic [PLEN_W-1:0]   res_plen
);

  logic [POS_W-1:0]    pos_r,   pos_nxt;
  logic [DATA_W-1:0]   dlen_r,  dlen_nxt;
  logic [DATA_W-1:0]   sum_r,   sum_nxt;
  logic [STATUS_W-1:0] ferr_r,  ferr_nxt;
  logic                eseen_r, eseen_nxt;

  logic                res_valid_r;
  logic [STATUS_W-1:0] res_status_r, res_status_nxt;
  logic [PLEN_W-1:0]   res_plen_r,   res_plen_nxt;

  logic                take;
  logic [DATA_W-1:0]   w;
  logic [DATA_W-1:0]   pos_w;
  logic [DATA_W-1:0]   acc;
  logic [DATA_W-1:0]   foot;
  logic [DATA_W-1:0]   foot_end;
  logic                chk_fail;
  logic [STATUS_W-1:0] chk_code;

  // a last word needs room in the result register
  assign up_ready = !up_word.last_word || !res_valid_r || res_ready;
  assign take     = up_valid && up_ready;

  assign w        = up_word.data_word;
  assign pos_w    = DATA_W'(pos_r);
  assign acc      = sum_r + w;
  assign foot     = dlen_r + HEADER_WORDS;
  assign foot_end = foot + 32'd2;

  always_comb begin
    chk_fail = 1'b0;
    chk_code = ST_OK;
    if (pos_r == POS_START) begin
      chk_fail = (w != START_WORD);
      chk_code = ST_START;
    end else if (pos_r == POS_MARKER) begin
      chk_fail = (w != MARKER_WORD);
      chk_code = ST_MARKER;
    end else if (pos_r == POS_SIZE) begin
      if (dlen_r != acc) begin
        chk_fail = 1'b1;
        chk_code = ST_MISMATCH;
      end else if (dlen_r == '0 || dlen_r >= PAYLOAD_LIMIT) begin
        chk_fail = 1'b1;
        chk_code = ST_RANGE;
      end
    end else if (pos_w >= HEADER_WORDS) begin
      if (pos_w == foot) begin
        chk_fail = (w != FOOTER_WORD);
        chk_code = ST_FOOTER;
      end else if (pos_w == foot_end) begin
        chk_fail = (w != END_WORD);
        chk_code = ST_END;
      end
    end
  end

  always_comb begin
    dlen_nxt  = dlen_r;
    sum_nxt   = sum_r;
    if (pos_r == POS_LENGTH) begin
      dlen_nxt = w - LEN_OFFSET;
    end else if (pos_r >= POS_SUM_LO && pos_r <= POS_SUM_HI) begin
      sum_nxt = acc;
    end
    eseen_nxt = eseen_r || chk_fail;
    ferr_nxt  = (!eseen_r && chk_fail) ? chk_code : ferr_r;
    pos_nxt   = (pos_r == POS_MAX) ? pos_r : pos_r + 1'b1;

    if (eseen_nxt) begin
      res_status_nxt = ferr_nxt;
    end else if (pos_w >= HEADER_WORDS && pos_w == foot_end) begin
      res_status_nxt = ST_OK;
    end else begin
      res_status_nxt = ST_LENGTH;
    end
    res_plen_nxt = (dlen_nxt > DATA_W'({PLEN_W{1'b1}})) ? {PLEN_W{1'b1}}
                                                        : dlen_nxt[PLEN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      dlen_r  <= '0;
      sum_r   <= '0;
      ferr_r  <= ST_OK;
      eseen_r <= 1'b0;
    end else if (take) begin
      if (up_word.last_word) begin
        // frame closed: start over
        pos_r   <= '0;
        dlen_r  <= '0;
        sum_r   <= '0;
        ferr_r  <= ST_OK;
        eseen_r <= 1'b0;
      end else begin
        pos_r   <= pos_nxt;
        dlen_r  <= dlen_nxt;
        sum_r   <= sum_nxt;
        ferr_r  <= ferr_nxt;
        eseen_r <= eseen_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (take && up_word.last_word) begin
      res_valid_r <= 1'b1;
    end else if (res_ready) begin
      res_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && up_word.last_word) begin
      res_status_r <= res_status_nxt;
      res_plen_r   <= res_plen_nxt;
    end
  end

  assign res_valid  = res_valid_r;
  assign res_status = res_status_r;
  assign res_plen   = res_plen_r;

endmodule

// File: hdl/event_frame_checker.sv
// Checks readout event frames that arrive one 32-bit word per transaction,
// last_word set on the final word. One result transaction follows each
// frame: status gives the first failed check in word order (bad start word,
// bad header marker, size mismatch, size out of range, bad first footer,
// bad end word) or a frame length error, else ok; payload_words is header
// word 8 minus 7, saturated to 16 bits. A word is taken every clock while
// no last word waits; a word passes an input register, then the check
// logic, and its result is registered when the core takes the last word.
// Only a last word waits when the result register is still occupied.
module event_frame_checker import efc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  efc_in_if.sink   in_chan,
  efc_out_if.source out_chan
);

  word_t in_word;
  word_t core_word;
  logic  core_valid;
  logic  core_ready;

  assign in_word.data_word = in_chan.data_word;
  assign in_word.last_word = in_chan.last_word;

  efc_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_chan.valid),
    .up_ready (in_chan.ready),
    .up_word  (in_word),
    .dn_valid (core_valid),
    .dn_ready (core_ready),
    .dn_word  (core_word)
  );

  efc_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .up_valid   (core_valid),
    .up_ready   (core_ready),
    .up_word    (core_word),
    .res_valid  (out_chan.valid),
    .res_ready  (out_chan.ready),
    .res_status (out_chan.status),
    .res_plen   (out_chan.payload_words)
  );

endmodule

// File: hdl/efc_checker.sv
module efc_checker import efc_pkg::*; (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input logic [STATUS_W-1:0] out_status,
  input logic [PLEN_W-1:0]   out_plen
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_status) && $stable(out_plen))
    else $error("result changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result shown right after reset");

  a_ok_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_OK |-> out_plen != '0)
    else $error("ok frame with empty payload");

endmodule

bind event_frame_checker efc_checker u_efc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_chan.valid),
  .out_ready  (out_chan.ready),
  .out_status (out_chan.status),
  .out_plen   (out_chan.payload_words)
);
